// ===== rtl/ges_pkg.sv =====
// package for the gillespie event step core: payload types and constants
package ges_pkg;

   localparam int unsigned RATE_W = 64;

   localparam logic [24:0] K_BS    = 25'd163840;
   localparam logic [24:0] K_DS    = 25'd32768;
   localparam logic [24:0] K_BR    = 25'd147456;
   localparam logic [24:0] K_DR    = 25'd32768;
   localparam logic [24:0] K_XI    = 25'd4915;
   localparam logic [24:0] K_ALPHA = 25'd3277;
   localparam logic [24:0] K_DELTA = 25'd3277;

   localparam logic [1:0] REG_KILL_MODE = 2'd0;
   localparam logic [1:0] REG_KILL_SENS = 2'd1;
   localparam logic [1:0] REG_KILL_RES  = 2'd2;
   localparam logic [1:0] REG_TREAT     = 2'd3;

   localparam logic [2:0] EV_SB = 3'd0;
   localparam logic [2:0] EV_SD = 3'd1;
   localparam logic [2:0] EV_RB = 3'd2;
   localparam logic [2:0] EV_RD = 3'd3;
   localparam logic [2:0] EV_IU = 3'd4;
   localparam logic [2:0] EV_ID = 3'd5;

   typedef struct packed {
      logic        start_run;
      logic [31:0] uniform_sample;
      logic [31:0] exp_sample;
      logic        mutate;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [15:0] sensitive_count;
      logic [15:0] resistant_count;
      logic [15:0] immune_count;
      logic        in_treatment;
      logic        run_done;
      logic        resistant_survived;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_XI2, ST_SCALE, ST_PICK, ST_DIV, ST_UPDATE, ST_OUT
   } state_type;

   // operand sets for the shared bit-serial multiplier
   typedef enum logic [3:0] {
      MJ_R0, MJ_R1, MJ_R2, MJ_R3, MJ_XS, MJ_XR, MJ_R4, MJ_R5,
      MJ_XSI, MJ_XRI, MJ_UH, MJ_UL
   } mjob_type;

endpackage

// ===== rtl/gillespie_event_step_core.sv =====
// gillespie direct-method event step core, bit-serial arithmetic
// steps from accepted word to result word: 12 multiplies (a zero-operand job
//    skips its shift-add steps), scale, pick, divide, update and the result
//    register; a finished run goes from multiply straight to output
// acceptance: a new word is taken only once the core is idle; the shared
//    shift-add multiplier and the restoring divider work one bit per cycle
// reset: synchronous, active high; populations 10,0,0, pre-treatment phase,
//    registers cleared
module gillespie_event_step_core
   import ges_pkg::*;
#(
   parameter int unsigned COUNT_BITS   = 16,
   parameter int unsigned SWITCH_LEVEL = 100
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic [63:0] RATE_CAP = (64'd1 << 60) - 64'd1;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] CNT_START = COUNT_BITS'(10);

   // configuration registers
   logic        kill_mode_ff;
   logic [24:0] kill_sens_ff, kill_res_ff;
   logic [31:0] treat_time_ff;
   logic        cfg_wr;

   // model state
   logic [COUNT_BITS-1:0] sens_ff, sens_in, res_ff, res_in, imm_ff, imm_in;
   logic        phase_ff, phase_in, done_ff, done_in;
   logic [31:0] elapsed_ff, elapsed_in;

   // per-event working registers
   state_type   state_ff, state_in;
   req_word_type req_ff;
   logic [63:0] rate_ff [6];
   logic [63:0] xs_ff, xr_ff;     // attack products before the immune factor
   logic [63:0] total_ff, scaled_ff;
   logic [2:0]  ev_ff;
   logic [2:0]  pick_ff;
   logic [63:0] cum_ff;
   mjob_type    job_ff;
   rsp_word_type rsp_ff;
   logic        rsp_valid_ff;

   // serial multiplier: 64-bit multiplicand, multiplier shifted out lsb first
   logic [63:0] m_acc_ff;     // low product (truncated), tracked overflow
   logic        m_ovf_ff;
   logic [63:0] m_a_ff;       // shifted multiplicand
   logic        m_aovf_ff;    // multiplicand has left 64 bits
   logic [63:0] m_b_ff;
   logic [6:0]  m_cnt_ff;

   // serial divider
   logic [71:0] d_num_ff;
   logic [72:0] d_rem_ff;
   logic [71:0] d_q_ff;
   logic [6:0]  d_cnt_ff;

   // ---------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         kill_mode_ff  <= 1'b0;
         kill_sens_ff  <= '0;
         kill_res_ff   <= '0;
         treat_time_ff <= '0;
      end else if (cfg_wr) begin
         case (csr_paddr[3:2])
            REG_KILL_MODE: kill_mode_ff  <= csr_pwdata[0];
            REG_KILL_SENS: kill_sens_ff  <= csr_pwdata[24:0];
            REG_KILL_RES:  kill_res_ff   <= csr_pwdata[24:0];
            REG_TREAT:     treat_time_ff <= csr_pwdata;
            default:       kill_mode_ff  <= kill_mode_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_KILL_MODE: csr_prdata = {31'd0, kill_mode_ff};
         REG_KILL_SENS: csr_prdata = {7'd0, kill_sens_ff};
         REG_KILL_RES:  csr_prdata = {7'd0, kill_res_ff};
         REG_TREAT:     csr_prdata = treat_time_ff;
         default:       csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // operands for each multiply job
   // ---------------------------------------------------------------
   logic [24:0] ks, kr, bs_net, br_net;
   logic [25:0] ds_net, dr_net;   // death rate plus kill can pass 25 bits
   logic [63:0] op_a, op_b;
   logic [COUNT_BITS:0] sr_sum;

   always_comb begin
      ks = phase_ff ? kill_sens_ff : '0;
      kr = phase_ff ? kill_res_ff : '0;
      if (kill_mode_ff == 1'b0) begin
         bs_net = (ks >= K_BS) ? '0 : K_BS - ks;
         br_net = (kr >= K_BR) ? '0 : K_BR - kr;
         ds_net = 26'(K_DS);
         dr_net = 26'(K_DR);
      end else begin
         bs_net = K_BS;
         br_net = K_BR;
         ds_net = 26'(K_DS) + 26'(ks);
         dr_net = 26'(K_DR) + 26'(kr);
      end
      sr_sum = {1'b0, sens_ff} + {1'b0, res_ff};
      case (job_ff)
         MJ_R0:   begin op_a = 64'(bs_net); op_b = 64'(sens_ff); end
         MJ_R1:   begin op_a = 64'(ds_net); op_b = 64'(sens_ff); end
         MJ_R2:   begin op_a = 64'(br_net); op_b = 64'(res_ff); end
         MJ_R3:   begin op_a = 64'(dr_net); op_b = 64'(res_ff); end
         MJ_XS:   begin op_a = 64'(K_XI); op_b = 64'(sens_ff); end
         MJ_XR:   begin op_a = 64'(K_XI); op_b = 64'(res_ff); end
         MJ_R4:   begin op_a = 64'(K_ALPHA); op_b = 64'(sr_sum); end
         MJ_R5:   begin op_a = 64'(K_DELTA); op_b = 64'(imm_ff); end
         MJ_XSI:  begin op_a = xs_ff; op_b = 64'(imm_ff); end
         MJ_XRI:  begin op_a = xr_ff; op_b = 64'(imm_ff); end
         MJ_UH:   begin op_a = {32'd0, total_ff[63:32]};
                        op_b = {32'd0, req_ff.uniform_sample}; end
         MJ_UL:   begin op_a = {32'd0, total_ff[31:0]};
                        op_b = {32'd0, req_ff.uniform_sample}; end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   // saturated product once the serial multiply has finished
   logic [63:0] m_sat;
   assign m_sat = (m_ovf_ff || m_acc_ff > RATE_CAP) ? RATE_CAP : m_acc_ff;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, RATE_CAP}) ? RATE_CAP : s[63:0];
   endfunction

   // ---------------------------------------------------------------
   // state machine: next state
   // ---------------------------------------------------------------
   logic m_last, d_last, pick_hit, in_acc, rsp_take;
   assign m_last   = (m_cnt_ff == 7'd63);
   assign d_last   = (d_cnt_ff == 7'd71);
   assign pick_hit = (scaled_ff < cum_ff + rate_ff[pick_ff]);
   assign in_acc   = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (in_acc) state_in = ST_MUL;
         ST_MUL:    if (done_ff) state_in = ST_OUT;
                    else if (m_last && job_ff == MJ_UL) state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_PICK;
         ST_PICK:   if (pick_hit || pick_ff == 3'd5) state_in = ST_DIV;
         ST_DIV:    if (d_last) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_OUT;
         ST_OUT:    if (!rsp_valid_ff || rsp_take) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // ---------------------------------------------------------------
   // datapath
   // ---------------------------------------------------------------
   logic [64:0] m_acc_sum;
   assign m_acc_sum = {1'b0, m_acc_ff} + {1'b0, m_a_ff};

   always_ff @(posedge clock) begin
      if (in_acc) begin
         req_ff   <= req_data;
         job_ff   <= MJ_R0;
         m_cnt_ff <= '0;
         m_acc_ff <= '0;
         m_ovf_ff <= 1'b0;
         m_b_ff   <= '0;
         m_a_ff   <= '0;
         m_aovf_ff <= 1'b0;
         // event code is zero for a finished run
         ev_ff    <= EV_SB;
      end
      case (state_ff)
         ST_MUL: begin
            // step 0 of each job loads operands, steps add one bit each
            if (m_cnt_ff == 7'd0 && m_b_ff == '0 && m_a_ff == '0
                && m_acc_ff == '0 && !m_ovf_ff) begin
               m_a_ff <= op_a; m_b_ff <= op_b; m_aovf_ff <= 1'b0;
               // a zero-operand job falls through with zero result
               if (op_a == '0 || op_b == '0) m_cnt_ff <= 7'd63;
               else m_cnt_ff <= 7'd1;
            end else if (m_last) begin
               case (job_ff)
                  MJ_R0:  begin rate_ff[0] <= m_sat; job_ff <= MJ_R1; end
                  MJ_R1:  begin rate_ff[1] <= m_sat; job_ff <= MJ_R2; end
                  MJ_R2:  begin rate_ff[2] <= m_sat; job_ff <= MJ_R3; end
                  MJ_R3:  begin rate_ff[3] <= m_sat; job_ff <= MJ_XS; end
                  MJ_XS:  begin xs_ff <= m_sat; job_ff <= MJ_XR; end
                  MJ_XR:  begin xr_ff <= m_sat; job_ff <= MJ_R4; end
                  MJ_R4:  begin rate_ff[4] <= m_sat; job_ff <= MJ_R5; end
                  MJ_R5:  begin rate_ff[5] <= m_sat; job_ff <= MJ_XSI; end
                  MJ_XSI: begin
                     rate_ff[1] <= sat_add(rate_ff[1], m_sat); job_ff <= MJ_XRI;
                  end
                  MJ_XRI: begin
                     rate_ff[3] <= sat_add(rate_ff[3], m_sat);
                     total_ff <= rate_ff[0] + rate_ff[1] + rate_ff[2]
                                 + sat_add(rate_ff[3], m_sat)
                                 + rate_ff[4] + rate_ff[5];
                     job_ff <= MJ_UH;
                  end
                  // scale products stay below 2^64, so the raw sum is exact
                  MJ_UH:  begin scaled_ff <= m_acc_ff; job_ff <= MJ_UL; end
                  MJ_UL:  begin scaled_ff <= scaled_ff + (m_acc_ff >> 32);
                                job_ff <= MJ_UL; end
                  default: job_ff <= MJ_R0;
               endcase
               m_cnt_ff <= '0; m_acc_ff <= '0; m_ovf_ff <= 1'b0;
               m_a_ff <= '0; m_b_ff <= '0;
            end else begin
               if (m_b_ff[0]) begin
                  if (m_aovf_ff || m_acc_sum[64]) m_ovf_ff <= 1'b1;
                  m_acc_ff <= m_acc_sum[63:0];
               end
               if (m_a_ff[63]) m_aovf_ff <= 1'b1;
               m_a_ff <= m_a_ff << 1;
               m_b_ff <= m_b_ff >> 1;
               m_cnt_ff <= m_cnt_ff + 7'd1;
            end
         end
         ST_SCALE: begin
            pick_ff <= 3'd0;
            cum_ff  <= '0;
         end
         ST_PICK: begin
            if (pick_hit) ev_ff <= pick_ff;
            else if (pick_ff == 3'd5) ev_ff <= EV_ID;
            cum_ff  <= cum_ff + rate_ff[pick_ff];
            pick_ff <= pick_ff + 3'd1;
            d_num_ff <= {req_ff.exp_sample, 40'd0} >> 32;
            d_rem_ff <= '0;
            d_q_ff   <= '0;
            d_cnt_ff <= '0;
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if ({d_rem_ff[71:0], d_num_ff[71]} >= {9'd0, total_ff}) begin
               d_rem_ff <= {d_rem_ff[71:0], d_num_ff[71]} - {9'd0, total_ff};
               d_q_ff   <= {d_q_ff[70:0], 1'b1};
            end else begin
               d_rem_ff <= {d_rem_ff[71:0], d_num_ff[71]};
               d_q_ff   <= {d_q_ff[70:0], 1'b0};
            end
            d_num_ff <= d_num_ff << 1;
            d_cnt_ff <= d_cnt_ff + 7'd1;
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------
   // model state update
   // ---------------------------------------------------------------
   logic [COUNT_BITS-1:0] s0, r0, i0, s1, r1, i1;
   logic [63:0] dt, tsum;

   always_comb begin
      s0 = req_ff.start_run ? CNT_START : sens_ff;
      r0 = req_ff.start_run ? '0 : res_ff;
      i0 = req_ff.start_run ? '0 : imm_ff;
      sens_in = sens_ff; res_in = res_ff; imm_in = imm_ff;
      phase_in = phase_ff; done_in = done_ff; elapsed_in = elapsed_ff;
      s1 = s0; r1 = r0; i1 = i0;
      dt = (total_ff == '0) ? '0 : d_q_ff[63:0];
      tsum = 64'(elapsed_ff) + dt;
      case (ev_ff)
         EV_SB: if (req_ff.mutate) r1 = (r0 == CNT_MAX) ? r0 : r0 + 1'b1;
                else s1 = (s0 == CNT_MAX) ? s0 : s0 + 1'b1;
         EV_SD: s1 = (s0 == '0) ? s0 : s0 - 1'b1;
         EV_RB: r1 = (r0 == CNT_MAX) ? r0 : r0 + 1'b1;
         EV_RD: r1 = (r0 == '0) ? r0 : r0 - 1'b1;
         EV_IU: i1 = (i0 == CNT_MAX) ? i0 : i0 + 1'b1;
         default: i1 = (i0 == '0) ? i0 : i0 - 1'b1;
      endcase
      if (state_ff == ST_UPDATE) begin
         sens_in = s1; res_in = r1; imm_in = i1;
         if (!phase_ff) begin
            if (s1 == '0 || 32'(s1) >= 32'(SWITCH_LEVEL)) begin
               res_in = COUNT_BITS'(1); phase_in = 1'b1; elapsed_in = '0;
            end
         end else begin
            if (tsum > 64'(treat_time_ff) || r1 == '0) done_in = 1'b1;
            elapsed_in = (tsum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tsum[31:0];
         end
      end
   end

   // start_run takes effect at acceptance so a finished run restarts at once
   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff <= CNT_START; res_ff <= '0; imm_ff <= '0;
         phase_ff <= 1'b0; done_ff <= 1'b0; elapsed_ff <= '0;
      end else if (in_acc && req_data.start_run) begin
         sens_ff <= CNT_START; res_ff <= '0; imm_ff <= '0;
         phase_ff <= 1'b0; done_ff <= 1'b0; elapsed_ff <= '0;
      end else begin
         sens_ff <= sens_in; res_ff <= res_in; imm_ff <= imm_in;
         phase_ff <= phase_in; done_ff <= done_in; elapsed_ff <= elapsed_in;
      end
   end

   // ---------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_take)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_take)) begin
         rsp_ff.event_res          <= ev_ff;
         rsp_ff.sensitive_count    <= 16'(sens_ff);
         rsp_ff.resistant_count    <= 16'(res_ff);
         rsp_ff.immune_count       <= 16'(imm_ff);
         rsp_ff.in_treatment       <= phase_ff;
         rsp_ff.run_done           <= done_ff;
         rsp_ff.resistant_survived <= done_ff && (res_ff != '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
